@@ sv/mslc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mslc_pkg
// Shared types and constants of the midpoint subdivision line clipper.
// ----------------------------------------------------------------------------
package mslc_pkg;

  // region code bits
  localparam logic [3:0] CODE_LEFT   = 4'd1;
  localparam logic [3:0] CODE_RIGHT  = 4'd2;
  localparam logic [3:0] CODE_BOTTOM = 4'd4;
  localparam logic [3:0] CODE_TOP    = 4'd8;

  // outcome codes
  localparam logic [1:0] OUT_ACCEPT = 2'd0;
  localparam logic [1:0] OUT_REJECT = 2'd1;
  localparam logic [1:0] OUT_CLIP   = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIN_LEFT   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIN_BOTTOM = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIN_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIN_TOP    = 2'd3;

  // window after reset
  localparam int WIN_LOW_RESET  = 10;
  localparam int WIN_HIGH_RESET = 50;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CODE_A,
    S_CODE_B,
    S_START,
    S_ITER,
    S_DONE
  } state_e;

  // flags from the shared midpoint and region unit
  typedef struct packed {
    logic [3:0] code;
    logic       close;
  } unit_res_t;

endpackage

@@ sv/seg_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seg_in_if
// Input channel: one line segment given by its two endpoints.
// ----------------------------------------------------------------------------
interface seg_in_if #(
  parameter int COORD_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

@@ sv/seg_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seg_out_if
// Output channel: outcome code and the visible segment.
// ----------------------------------------------------------------------------
interface seg_out_if #(
  parameter int COORD_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            outcome;
  logic [COORD_BITS-1:0] clip_start_x;
  logic [COORD_BITS-1:0] clip_start_y;
  logic [COORD_BITS-1:0] clip_end_x;
  logic [COORD_BITS-1:0] clip_end_y;

  modport source (output valid, outcome, clip_start_x, clip_start_y, clip_end_x,
                  clip_end_y, input ready);
  modport sink   (input valid, outcome, clip_start_x, clip_start_y, clip_end_x,
                  clip_end_y, output ready);
endinterface

@@ sv/midpoint_subdivision_line_clip.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_subdivision_line_clip
// Clips one segment per word against an inclusive window by midpoint search.
// ----------------------------------------------------------------------------
// One segment word is taken at a time. States S_CODE_A and S_CODE_B compute
// the endpoint region codes; a fully visible or trivially rejected segment
// then goes through S_DONE to the output register. Otherwise each end is
// found by a binary midpoint search in which each S_ITER visit is one pass of
// the shared midpoint/region unit, halving until the two points are adjacent,
// plus one final check per end. The search loop runs through that single
// unit. A finished word waits in the output register while the next segment
// is taken. The user must write the window registers only while idle; the
// block itself does not enforce it.
module midpoint_subdivision_line_clip #(
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mslc_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [COORD_BITS-1:0]                 cfg_data_i,
  seg_in_if.sink                                seg_in,
  seg_out_if.source                             seg_out
);
  import mslc_pkg::*;

  state_e state_q, state_d;

  logic [COORD_BITS-1:0] win_left_q, win_bottom_q, win_right_q, win_top_q;
  logic [COORD_BITS-1:0] a_x_q, a_y_q, b_x_q, b_y_q;
  logic [COORD_BITS-1:0] a_x_d, a_y_d, b_x_d, b_y_d;
  logic [COORD_BITS-1:0] p_x_q, p_y_q, q_x_q, q_y_q;
  logic [COORD_BITS-1:0] p_x_d, p_y_d, q_x_d, q_y_d;
  logic [3:0]            ca_q, cb_q, cp_q, cq_q;
  logic [3:0]            ca_d, cb_d, cp_d, cq_d;
  logic                  side_q, side_d;
  logic [1:0]            res_oc_q, res_oc_d;
  logic [COORD_BITS-1:0] res_sx_q, res_sy_q, res_ex_q, res_ey_q;
  logic [COORD_BITS-1:0] res_sx_d, res_sy_d, res_ex_d, res_ey_d;

  logic                  out_valid_q, out_valid_d;
  logic [1:0]            out_oc_q;
  logic [COORD_BITS-1:0] out_sx_q, out_sy_q, out_ex_q, out_ey_q;
  logic                  out_load;

  logic [COORD_BITS-1:0] u_p_x, u_p_y, u_q_x, u_q_y;
  logic [COORD_BITS-1:0] mid_x, mid_y;
  logic                  sel_mid;
  unit_res_t             unit_res;
  logic [COORD_BITS-1:0] near_x, near_y;
  logic [3:0]            near_code;

  // window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q   <= COORD_BITS'(WIN_LOW_RESET);
      win_bottom_q <= COORD_BITS'(WIN_LOW_RESET);
      win_right_q  <= COORD_BITS'(WIN_HIGH_RESET);
      win_top_q    <= COORD_BITS'(WIN_HIGH_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIN_LEFT:   win_left_q   <= cfg_data_i;
        REG_WIN_BOTTOM: win_bottom_q <= cfg_data_i;
        REG_WIN_RIGHT:  win_right_q  <= cfg_data_i;
        REG_WIN_TOP:    win_top_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shared unit operand selection
  always_comb begin
    sel_mid = 1'b0;
    u_p_x   = p_x_q;
    u_p_y   = p_y_q;
    u_q_x   = q_x_q;
    u_q_y   = q_y_q;
    case (state_q)
      S_CODE_A: begin
        u_p_x = a_x_q;
        u_p_y = a_y_q;
      end
      S_CODE_B: begin
        u_p_x = b_x_q;
        u_p_y = b_y_q;
      end
      S_ITER:  sel_mid = 1'b1;
      default: ;
    endcase
  end

  mslc_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_unit (
    .win_left_i   (win_left_q),
    .win_bottom_i (win_bottom_q),
    .win_right_i  (win_right_q),
    .win_top_i    (win_top_q),
    .p_x_i        (u_p_x),
    .p_y_i        (u_p_y),
    .q_x_i        (u_q_x),
    .q_y_i        (u_q_y),
    .sel_mid_i    (sel_mid),
    .mid_x_o      (mid_x),
    .mid_y_o      (mid_y),
    .res_o        (unit_res)
  );

  // near end of the current search
  assign near_x    = side_q ? b_x_q : a_x_q;
  assign near_y    = side_q ? b_y_q : a_y_q;
  assign near_code = side_q ? cb_q : ca_q;

  assign seg_in.ready = (state_q == S_IDLE);
  assign out_load     = (state_q == S_DONE) && (!out_valid_q || seg_out.ready);

  // sequencer
  always_comb begin
    state_d  = state_q;
    a_x_d    = a_x_q;
    a_y_d    = a_y_q;
    b_x_d    = b_x_q;
    b_y_d    = b_y_q;
    p_x_d    = p_x_q;
    p_y_d    = p_y_q;
    q_x_d    = q_x_q;
    q_y_d    = q_y_q;
    ca_d     = ca_q;
    cb_d     = cb_q;
    cp_d     = cp_q;
    cq_d     = cq_q;
    side_d   = side_q;
    res_oc_d = res_oc_q;
    res_sx_d = res_sx_q;
    res_sy_d = res_sy_q;
    res_ex_d = res_ex_q;
    res_ey_d = res_ey_q;
    case (state_q)
      S_IDLE: begin
        if (seg_in.valid) begin
          a_x_d   = seg_in.start_x;
          a_y_d   = seg_in.start_y;
          b_x_d   = seg_in.end_x;
          b_y_d   = seg_in.end_y;
          state_d = S_CODE_A;
        end
      end
      S_CODE_A: begin
        ca_d    = unit_res.code;
        state_d = S_CODE_B;
      end
      S_CODE_B: begin
        cb_d = unit_res.code;
        if ((ca_q | unit_res.code) == 4'd0) begin
          res_oc_d = OUT_ACCEPT;
          res_sx_d = a_x_q;
          res_sy_d = a_y_q;
          res_ex_d = b_x_q;
          res_ey_d = b_y_q;
          state_d  = S_DONE;
        end else if ((ca_q & unit_res.code) != 4'd0) begin
          res_oc_d = OUT_REJECT;
          res_sx_d = '0;
          res_sy_d = '0;
          res_ex_d = '0;
          res_ey_d = '0;
          state_d  = S_DONE;
        end else begin
          side_d  = 1'b0;
          state_d = S_START;
        end
      end
      // set up the search of one end
      S_START: begin
        if (near_code == 4'd0) begin
          if (side_q) begin
            res_ex_d = b_x_q;
            res_ey_d = b_y_q;
            res_oc_d = OUT_CLIP;
            state_d  = S_DONE;
          end else begin
            res_sx_d = a_x_q;
            res_sy_d = a_y_q;
            side_d   = 1'b1;
          end
        end else begin
          p_x_d   = near_x;
          p_y_d   = near_y;
          q_x_d   = side_q ? a_x_q : b_x_q;
          q_y_d   = side_q ? a_y_q : b_y_q;
          cp_d    = near_code;
          cq_d    = side_q ? ca_q : cb_q;
          state_d = S_ITER;
        end
      end
      // one halving step per cycle until the search ends
      S_ITER: begin
        if (((cp_q & cq_q) != 4'd0) || (unit_res.close && (cq_q != 4'd0))) begin
          res_oc_d = OUT_REJECT;
          res_sx_d = '0;
          res_sy_d = '0;
          res_ex_d = '0;
          res_ey_d = '0;
          state_d  = S_DONE;
        end else if (unit_res.close) begin
          if (side_q) begin
            res_ex_d = q_x_q;
            res_ey_d = q_y_q;
            res_oc_d = OUT_CLIP;
            state_d  = S_DONE;
          end else begin
            res_sx_d = q_x_q;
            res_sy_d = q_y_q;
            side_d   = 1'b1;
            state_d  = S_START;
          end
        end else if ((unit_res.code == 4'd0) ||
                     (((unit_res.code & cp_q) == 4'd0) &&
                      ((unit_res.code & cq_q) != 4'd0))) begin
          q_x_d = mid_x;
          q_y_d = mid_y;
          cq_d  = unit_res.code;
        end else begin
          p_x_d = mid_x;
          p_y_d = mid_y;
          cp_d  = unit_res.code;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      side_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      side_q      <= side_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    a_x_q    <= a_x_d;
    a_y_q    <= a_y_d;
    b_x_q    <= b_x_d;
    b_y_q    <= b_y_d;
    p_x_q    <= p_x_d;
    p_y_q    <= p_y_d;
    q_x_q    <= q_x_d;
    q_y_q    <= q_y_d;
    ca_q     <= ca_d;
    cb_q     <= cb_d;
    cp_q     <= cp_d;
    cq_q     <= cq_d;
    res_oc_q <= res_oc_d;
    res_sx_q <= res_sx_d;
    res_sy_q <= res_sy_d;
    res_ex_q <= res_ex_d;
    res_ey_q <= res_ey_d;
  end

  // output word register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (seg_out.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_oc_q <= res_oc_q;
      out_sx_q <= res_sx_q;
      out_sy_q <= res_sy_q;
      out_ex_q <= res_ex_q;
      out_ey_q <= res_ey_q;
    end
  end

  assign seg_out.valid        = out_valid_q;
  assign seg_out.outcome      = out_oc_q;
  assign seg_out.clip_start_x = out_sx_q;
  assign seg_out.clip_start_y = out_sy_q;
  assign seg_out.clip_end_x   = out_ex_q;
  assign seg_out.clip_end_y   = out_ey_q;

endmodule

@@ sv/mslc_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mslc_unit
// Shared midpoint, region code and adjacency unit used by the sequencer.
// ----------------------------------------------------------------------------
module mslc_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic [COORD_BITS-1:0] win_left_i,
  input  logic [COORD_BITS-1:0] win_bottom_i,
  input  logic [COORD_BITS-1:0] win_right_i,
  input  logic [COORD_BITS-1:0] win_top_i,
  input  logic [COORD_BITS-1:0] p_x_i,
  input  logic [COORD_BITS-1:0] p_y_i,
  input  logic [COORD_BITS-1:0] q_x_i,
  input  logic [COORD_BITS-1:0] q_y_i,
  input  logic                  sel_mid_i,
  output logic [COORD_BITS-1:0] mid_x_o,
  output logic [COORD_BITS-1:0] mid_y_o,
  output mslc_pkg::unit_res_t   res_o
);
  import mslc_pkg::*;

  logic [COORD_BITS:0]   sum_x, sum_y;
  logic [COORD_BITS:0]   dif_x, dif_y;
  logic [COORD_BITS-1:0] r_x, r_y;
  logic                  near_x, near_y;

  // floor of the half sum: arithmetic shift of the widened sum
  assign sum_x   = {p_x_i[COORD_BITS-1], p_x_i} + {q_x_i[COORD_BITS-1], q_x_i};
  assign sum_y   = {p_y_i[COORD_BITS-1], p_y_i} + {q_y_i[COORD_BITS-1], q_y_i};
  assign mid_x_o = sum_x[COORD_BITS:1];
  assign mid_y_o = sum_y[COORD_BITS:1];

  // endpoints at most one apart in each axis
  assign dif_x  = {p_x_i[COORD_BITS-1], p_x_i} - {q_x_i[COORD_BITS-1], q_x_i};
  assign dif_y  = {p_y_i[COORD_BITS-1], p_y_i} - {q_y_i[COORD_BITS-1], q_y_i};
  assign near_x = (dif_x == '0) || (dif_x == (COORD_BITS+1)'(1)) || (dif_x == '1);
  assign near_y = (dif_y == '0) || (dif_y == (COORD_BITS+1)'(1)) || (dif_y == '1);

  // region code of the midpoint or of p
  assign r_x = sel_mid_i ? mid_x_o : p_x_i;
  assign r_y = sel_mid_i ? mid_y_o : p_y_i;

  always_comb begin
    res_o.code  = 4'd0;
    res_o.close = near_x && near_y;
    if ($signed(r_x) < $signed(win_left_i)) begin
      res_o.code = res_o.code | CODE_LEFT;
    end else if ($signed(r_x) > $signed(win_right_i)) begin
      res_o.code = res_o.code | CODE_RIGHT;
    end
    if ($signed(r_y) < $signed(win_bottom_i)) begin
      res_o.code = res_o.code | CODE_BOTTOM;
    end else if ($signed(r_y) > $signed(win_top_i)) begin
      res_o.code = res_o.code | CODE_TOP;
    end
  end

endmodule

@@ test/clip_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clip_checker
// Watches the segment channels and the window port, predicts each clip
// result, and compares it field by field with the word the block returns.
// ----------------------------------------------------------------------------
module clip_checker #(
  parameter int COORD_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mslc_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]             cfg_data_i,
  seg_in_if                                 seg_in,
  seg_out_if                                seg_out,
  output int unsigned                       fail_cnt_o,
  output int unsigned                       pending_o
);
  import mslc_pkg::*;

  localparam int REPORT_LIMIT = 10;
  localparam int SEARCH_STEPS = 4 * COORD_BITS + 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   wide_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    logic [1:0] outcome;
    coord_t     sx;
    coord_t     sy;
    coord_t     ex;
    coord_t     ey;
  } clip_res_t;

  coord_t    win_left_q, win_bottom_q, win_right_q, win_top_q;
  clip_res_t pending_clips[$];

  // local copy of the window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q   <= coord_t'(WIN_LOW_RESET);
      win_bottom_q <= coord_t'(WIN_LOW_RESET);
      win_right_q  <= coord_t'(WIN_HIGH_RESET);
      win_top_q    <= coord_t'(WIN_HIGH_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIN_LEFT:   win_left_q   <= cfg_data_i;
        REG_WIN_BOTTOM: win_bottom_q <= cfg_data_i;
        REG_WIN_RIGHT:  win_right_q  <= cfg_data_i;
        REG_WIN_TOP:    win_top_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // region code; left wins over right, bottom over top
  function automatic logic [3:0] region_of(point_t p);
    logic [3:0] c;
    c = '0;
    if (p.x < win_left_q) c |= CODE_LEFT;
    else if (p.x > win_right_q) c |= CODE_RIGHT;
    if (p.y < win_bottom_q) c |= CODE_BOTTOM;
    else if (p.y > win_top_q) c |= CODE_TOP;
    return c;
  endfunction

  // floor midpoint, one extra bit for the sum
  function automatic point_t mid_of(point_t a, point_t b);
    wide_t  sx, sy;
    point_t m;
    sx = wide_t'(a.x) + wide_t'(b.x);
    sy = wide_t'(a.y) + wide_t'(b.y);
    m.x = sx[COORD_BITS:1];
    m.y = sy[COORD_BITS:1];
    return m;
  endfunction

  function automatic logic is_close(point_t a, point_t b);
    wide_t dx, dy;
    dx = wide_t'(a.x) - wide_t'(b.x);
    dy = wide_t'(a.y) - wide_t'(b.y);
    return (dx >= -1) && (dx <= 1) && (dy >= -1) && (dy <= 1);
  endfunction

  // visible point nearest to near_pt on the segment toward far_pt
  function automatic logic nearest_visible(point_t near_pt, point_t far_pt,
                                           output point_t hit);
    point_t     p, q, m;
    logic [3:0] cp, cq, cm;
    p   = near_pt;
    q   = far_pt;
    hit = '0;
    if (region_of(p) == '0) begin
      hit = p;
      return 1'b1;
    end
    for (int i = 0; i < SEARCH_STEPS; i++) begin
      cp = region_of(p);
      cq = region_of(q);
      if ((cp & cq) != '0) return 1'b0;
      if (is_close(p, q)) break;
      m  = mid_of(p, q);
      cm = region_of(m);
      if (cm == '0) q = m;
      else if ((cm & cp) != '0) p = m;
      else if ((cm & cq) != '0) q = m;
      else p = m;
    end
    if (region_of(q) == '0) begin
      hit = q;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic clip_res_t clip_segment(point_t a, point_t b);
    clip_res_t  r;
    point_t     ca, cb;
    logic [3:0] ka, kb;
    logic       ok_a, ok_b;
    r  = '0;
    ka = region_of(a);
    kb = region_of(b);
    if ((ka | kb) == '0) begin
      r.outcome = OUT_ACCEPT;
      r.sx = a.x; r.sy = a.y; r.ex = b.x; r.ey = b.y;
    end else if ((ka & kb) != '0) begin
      r.outcome = OUT_REJECT;
    end else begin
      ok_a = nearest_visible(a, b, ca);
      ok_b = nearest_visible(b, a, cb);
      if (ok_a && ok_b) begin
        r.outcome = OUT_CLIP;
        r.sx = ca.x; r.sy = ca.y; r.ex = cb.x; r.ey = cb.y;
      end else begin
        r.outcome = OUT_REJECT;
      end
    end
    return r;
  endfunction

  task automatic note_failure(string what, clip_res_t want, clip_res_t got);
    fail_cnt_o++;
    if (fail_cnt_o <= REPORT_LIMIT)
      $display("%0t: %s: want %0d (%0d,%0d)-(%0d,%0d) got %0d (%0d,%0d)-(%0d,%0d)",
               $realtime, what, want.outcome, want.sx, want.sy, want.ex, want.ey,
               got.outcome, got.sx, got.sy, got.ex, got.ey);
  endtask

  // compare returned words, then queue the prediction for a new segment
  always @(posedge clk_i) begin
    clip_res_t got, want;
    point_t    a, b;
    if (!rst_ni) begin
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (seg_out.valid && seg_out.ready) begin
        got.outcome = seg_out.outcome;
        got.sx      = seg_out.clip_start_x;
        got.sy      = seg_out.clip_start_y;
        got.ex      = seg_out.clip_end_x;
        got.ey      = seg_out.clip_end_y;
        if (pending_clips.size() == 0) begin
          note_failure("result word with nothing expected", '0, got);
        end else begin
          want = pending_clips.pop_front();
          if (got.outcome !== want.outcome || got.sx !== want.sx ||
              got.sy !== want.sy || got.ex !== want.ex || got.ey !== want.ey)
            note_failure("clip mismatch", want, got);
        end
      end
      if (seg_in.valid && seg_in.ready) begin
        a.x = seg_in.start_x;
        a.y = seg_in.start_y;
        b.x = seg_in.end_x;
        b.y = seg_in.end_y;
        pending_clips.push_back(clip_segment(a, b));
      end
      pending_o = pending_clips.size();
    end
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives segments and window settings into the line clipper with random
// gaps and stalls on both channels; the checker beside it judges results.
// ----------------------------------------------------------------------------
module tb;
  import mslc_pkg::*;

  localparam int COORD_BITS   = 16;
  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 12;
  localparam int IDLE_PCT     = 28;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_GAP   = 4;
  localparam int DRAIN_CYCLES = 60;
  localparam int LIMIT_NS     = 6_000_000;
  localparam int COORD_MIN    = -(2 ** (COORD_BITS - 1));
  localparam int COORD_MAX    = 2 ** (COORD_BITS - 1) - 1;

  logic                    clk_i    = 1'b0;
  logic                    rst_ni   = 1'b0;
  logic                    cfg_we   = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx  = REG_WIN_LEFT;
  logic [COORD_BITS-1:0]   cfg_data = '0;

  int unsigned clip_fails, clips_pending;
  bit          no_idle    = 1'b0;
  int          hold_asked = 0;
  int          hold_seen  = 0;
  int          win_l      = WIN_LOW_RESET;
  int          win_b      = WIN_LOW_RESET;
  int          win_r      = WIN_HIGH_RESET;
  int          win_t      = WIN_HIGH_RESET;

  seg_in_if  #(.COORD_BITS(COORD_BITS)) seg_in ();
  seg_out_if #(.COORD_BITS(COORD_BITS)) seg_out ();

  midpoint_subdivision_line_clip #(.COORD_BITS(COORD_BITS)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .seg_in     (seg_in),
    .seg_out    (seg_out)
  );

  clip_checker #(.COORD_BITS(COORD_BITS)) u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .seg_in     (seg_in),
    .seg_out    (seg_out),
    .fail_cnt_o (clip_fails),
    .pending_o  (clips_pending)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  function automatic int clamp_coord(int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // mostly near the window edges, some full range and some extremes
  function automatic int pick_coord(int lo, int hi);
    int a, b, span, v;
    a    = (lo < hi) ? lo : hi;
    b    = (lo < hi) ? hi : lo;
    span = (b - a) + 8;
    case ($urandom_range(0, 9))
      0, 1: v = int'($urandom_range(0, 65535)) + COORD_MIN;
      2: begin
        case ($urandom_range(0, 5))
          0: v = COORD_MIN;
          1: v = COORD_MAX;
          2: v = a;
          3: v = b;
          4: v = a - 1;
          default: v = b + 1;
        endcase
      end
      default: v = a - span + int'($urandom_range(0, 3 * span));
    endcase
    return clamp_coord(v);
  endfunction

  // one segment word, with random idle cycles ahead of it
  task automatic send_seg(int sx, int sy, int ex, int ey);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      seg_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    seg_in.valid   <= 1'b1;
    seg_in.start_x <= sx[COORD_BITS-1:0];
    seg_in.start_y <= sy[COORD_BITS-1:0];
    seg_in.end_x   <= ex[COORD_BITS-1:0];
    seg_in.end_y   <= ey[COORD_BITS-1:0];
    do @(posedge clk_i); while (!seg_in.ready);
    @(negedge clk_i);
  endtask

  task automatic send_random(int count);
    int sx, sy;
    for (int i = 0; i < count; i++) begin
      sx = pick_coord(win_l, win_r);
      sy = pick_coord(win_b, win_t);
      if ($urandom_range(0, 9) == 0) send_seg(sx, sy, sx, sy);
      else send_seg(sx, sy, pick_coord(win_l, win_r), pick_coord(win_b, win_t));
    end
  endtask

  // stop offering and wait until every clip result is back
  task automatic settle();
    seg_in.valid <= 1'b0;
    while (clips_pending != 0) @(negedge clk_i);
    repeat (SETTLE_GAP) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[COORD_BITS-1:0];
    @(negedge clk_i);
  endtask

  task automatic set_window(int l, int b, int r, int t);
    settle();
    write_reg(REG_WIN_LEFT, l);
    write_reg(REG_WIN_BOTTOM, b);
    write_reg(REG_WIN_RIGHT, r);
    write_reg(REG_WIN_TOP, t);
    cfg_we <= 1'b0;
    @(negedge clk_i);
    win_l = l; win_b = b; win_r = r; win_t = t;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    seg_out.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_asked != hold_seen) begin
        hold_seen = hold_asked;
        seg_out.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        seg_out.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // stimulus and verdict
  initial begin
    int l, b, r, t, w;
    seg_in.valid   = 1'b0;
    seg_in.start_x = '0;
    seg_in.start_y = '0;
    seg_in.end_x   = '0;
    seg_in.end_y   = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed segments against the reset window
    send_seg(20, 20, 40, 40);
    send_seg(10, 10, 50, 50);
    send_seg(30, 30, 30, 30);
    send_seg(0, 0, 0, 0);
    send_seg(0, 20, 5, 30);
    send_seg(60, 20, 70, 45);
    send_seg(20, 0, 40, 5);
    send_seg(20, 60, 40, 70);
    send_seg(0, 30, 30, 30);
    send_seg(30, 30, 60, 30);
    send_seg(0, 0, 60, 60);
    send_seg(8, 49, 11, 52);          // slips past the corner, no visible point
    send_seg(9, 30, 10, 30);
    send_seg(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_seg(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    send_seg(COORD_MIN, 30, COORD_MAX, 30);
    send_seg(30, COORD_MAX, 30, COORD_MIN);
    send_seg(0, 55, 55, 0);
    send_seg(-1, -1, -1, -1);
    send_seg(30, -1, -1, 30);

    // long stretch without idling on either side
    no_idle = 1'b1;
    send_random(60);
    no_idle = 1'b0;

    // receiver holds off while segments keep coming
    hold_asked++;
    send_random(40);
    send_random(100);

    // full-range window, every segment visible
    set_window(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_random(40);

    // inverted windows, nothing visible
    set_window(50, 10, 10, 50);
    send_seg(30, 30, 30, 30);
    send_seg(0, 30, 60, 30);
    send_random(15);
    set_window(10, 50, 50, 10);
    send_seg(30, 30, 30, 30);
    send_random(15);

    // single-point window and windows in the far corners
    set_window(0, 0, 0, 0);
    send_random(40);
    set_window(COORD_MAX - 7, COORD_MAX - 7, COORD_MAX, COORD_MAX);
    send_random(40);
    set_window(COORD_MIN, COORD_MIN, COORD_MIN + 7, COORD_MIN + 7);
    send_random(40);

    // random windows, mostly small
    for (int k = 0; k < 8; k++) begin
      l = int'($urandom_range(0, 65535)) + COORD_MIN;
      b = int'($urandom_range(0, 65535)) + COORD_MIN;
      w = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                      : int'($urandom_range(0, 200));
      r = clamp_coord(l + w);
      w = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                      : int'($urandom_range(0, 200));
      t = clamp_coord(b + w);
      if ($urandom_range(0, 7) == 0) set_window(r, b, l, t);
      else set_window(l, b, r, t);
      send_random(38);
    end

    seg_in.valid <= 1'b0;
    while (clips_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (clip_fails == 0 && clips_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin
    #(LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule
